// ===== rtl/hrd_pkg.sv =====
// Shared types and constants for the HTTP response body deframer.
// Used by every module in rtl; depends on nothing.
package hrd_pkg;

    localparam int NAME_LEN = 16;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [7:0] NAME_TEXT [NAME_LEN] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
    };

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1
    } phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_payload;
        logic        header_done;
        logic        length_known;
        logic [31:0] content_length;
        logic [31:0] body_count;
        logic        last;
    } hrd_result_t;

endpackage

// ===== rtl/hrd_in_stage.sv =====
// Input register of the deframer: holds one received byte until the parser takes it.
// Depends on hrd_pkg.
module hrd_in_stage
    import hrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       go,
    output logic [7:0] byte_q
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign go       = valid_reg && advance;
    assign in_stall = valid_reg && !advance;
    assign byte_q   = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

// ===== rtl/hrd_parser.sv =====
// Parser state and its combinational update for one byte: name match, digit
// accumulation, end-of-header detection and body counting. Depends on hrd_pkg.
module hrd_parser
    import hrd_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [7:0]  byte_q,
    output hrd_result_t result
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    phase_t                 phase_reg, phase_next;
    logic [4:0]             name_idx_reg, name_idx_next;
    logic                   reading_reg, reading_next;
    logic                   stopped_reg, stopped_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    logic                   seen_reg, seen_next;
    logic [1:0]             blank_reg, blank_next;
    logic [LENGTH_BITS-1:0] body_reg, body_next;

    logic [LENGTH_BITS+3:0] scaled;
    logic [LENGTH_BITS-1:0] len_upd;
    logic [LENGTH_BITS-1:0] body_upd;
    logic [31:0]            len_out;
    logic [31:0]            body_out;
    logic                   payload;
    logic                   hdone;
    logic                   fin;
    logic [4:0]             idx;
    logic [1:0]             m;
    logic [7:0]             blank_char;

    assign scaled = ({4'b0, length_reg} << 3) + ({4'b0, length_reg} << 1)
                  + (LENGTH_BITS+4)'(byte_q - CHAR_ZERO);

    generate
        if (LENGTH_BITS > 32)
        begin : g_wide
            assign len_out  = (|len_upd[LENGTH_BITS-1:32]) ? 32'hFFFF_FFFF : len_upd[31:0];
            assign body_out = (|body_upd[LENGTH_BITS-1:32]) ? 32'hFFFF_FFFF : body_upd[31:0];
        end
        else
        begin : g_narrow
            assign len_out  = 32'(len_upd);
            assign body_out = 32'(body_upd);
        end
    endgenerate

    always_comb
    begin
        phase_next    = phase_reg;
        name_idx_next = name_idx_reg;
        reading_next  = reading_reg;
        stopped_next  = stopped_reg;
        length_next   = length_reg;
        seen_next     = seen_reg;
        blank_next    = blank_reg;
        body_next     = body_reg;
        payload       = 1'b0;
        hdone         = 1'b0;
        fin           = 1'b0;
        idx           = 5'd0;
        m             = blank_reg;
        blank_char    = CHAR_CR;

        case (phase_reg)
            PH_BODY:
            begin
                payload   = 1'b1;
                hdone     = 1'b1;
                body_next = (body_reg == LEN_MAX) ? body_reg : body_reg + 1'b1;
                fin       = (body_next >= length_reg);
            end
            default:
            begin
                if (reading_reg)
                begin
                    if (byte_q == CHAR_CR)
                    begin
                        reading_next = 1'b0;
                        seen_next    = 1'b1;
                    end
                    else if (!stopped_reg && (byte_q inside {[CHAR_ZERO:CHAR_NINE]}))
                    begin
                        length_next = (|scaled[LENGTH_BITS+3:LENGTH_BITS])
                                    ? LEN_MAX : scaled[LENGTH_BITS-1:0];
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
                else if (!seen_reg)
                begin
                    idx = name_idx_reg[4] ? 5'd0 : name_idx_reg;
                    if (byte_q == NAME_TEXT[idx[3:0]])
                    begin
                        idx = idx + 5'd1;
                    end
                    else
                    begin
                        idx = (byte_q == NAME_TEXT[0]) ? 5'd1 : 5'd0;
                    end
                    if (idx[4])
                    begin
                        reading_next = 1'b1;
                        stopped_next = 1'b0;
                        length_next  = '0;
                        idx          = 5'd0;
                    end
                    name_idx_next = idx;
                end

                blank_char = m[0] ? CHAR_LF : CHAR_CR;
                if (byte_q == blank_char)
                begin
                    if (m == 2'd3)
                    begin
                        hdone = 1'b1;
                        m     = 2'd0;
                    end
                    else
                    begin
                        m = m + 2'd1;
                    end
                end
                else
                begin
                    m = (byte_q == CHAR_CR) ? 2'd1 : 2'd0;
                end
                blank_next = m;

                if (hdone)
                begin
                    phase_next = PH_BODY;
                    body_next  = '0;
                    fin        = !seen_next || (length_next == '0);
                end
            end
        endcase
    end

    assign len_upd  = length_next;
    assign body_upd = body_next;

    always_comb
    begin
        result.data_byte      = byte_q;
        result.is_payload     = payload;
        result.header_done    = hdone;
        result.length_known   = seen_next;
        result.content_length = len_out;
        result.body_count     = payload ? body_out : 32'd0;
        result.last           = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            name_idx_reg <= 5'd0;
            reading_reg  <= 1'b0;
            stopped_reg  <= 1'b0;
            length_reg   <= '0;
            seen_reg     <= 1'b0;
            blank_reg    <= 2'd0;
            body_reg     <= '0;
        end
        else if (go)
        begin
            if (fin)
            begin
                phase_reg    <= PH_HEADER;
                name_idx_reg <= 5'd0;
                reading_reg  <= 1'b0;
                stopped_reg  <= 1'b0;
                length_reg   <= '0;
                seen_reg     <= 1'b0;
                blank_reg    <= 2'd0;
                body_reg     <= '0;
            end
            else
            begin
                phase_reg    <= phase_next;
                name_idx_reg <= name_idx_next;
                reading_reg  <= reading_next;
                stopped_reg  <= stopped_next;
                length_reg   <= length_next;
                seen_reg     <= seen_next;
                blank_reg    <= blank_next;
                body_reg     <= body_next;
            end
        end
    end

    // A finished response leaves the parser back at the start of a header.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        go && fin |=> phase_reg == PH_HEADER && body_reg == '0 && !seen_reg)
        else $error("parser did not restart after the last byte");

    // Digits are read only before the length is known.
    a_digits_before_seen: assert property (@(posedge clk) disable iff (!rst_n)
        reading_reg |-> !seen_reg)
        else $error("digit reading active after length was known");

    // The blank-line matcher is idle during the body.
    a_body_blank_idle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> blank_reg == 2'd0)
        else $error("blank-line matcher busy in body phase");

endmodule

// ===== rtl/hrd_out_stage.sv =====
// Result register of the deframer: holds one result beat until the receiver takes it.
// Depends on hrd_pkg.
module hrd_out_stage
    import hrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  hrd_result_t result,
    output logic        advance,
    output logic        out_valid,
    input  logic        out_stall,
    output hrd_result_t result_q
);

    logic        valid_reg;
    hrd_result_t result_reg;

    assign advance   = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign result_q  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            result_reg <= result;
        end
    end

endmodule

// ===== rtl/http_response_body_deframer_top.sv =====
// Takes one response byte per beat and returns one result beat per byte,
// marking header, body and the last byte of each response. Depends on hrd_pkg.
//
// One byte is accepted in every cycle while the output is not stalled; each byte
// passes the input register, then the result register that offers its beat. The
// rate is set by the parser state update, which handles one whole byte
// combinationally between the input register and the result register. The parsed
// length is LENGTH_BITS wide internally and is reported saturated to 32 bits.
module http_response_body_deframer_top
    import hrd_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic        is_payload,
    output logic        header_done,
    output logic        length_known,
    output logic [31:0] content_length,
    output logic [31:0] body_count,
    output logic        last
);

    logic        advance;
    logic        go;
    logic [7:0]  byte_q;
    hrd_result_t result;
    hrd_result_t result_q;

    hrd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .go       (go),
        .byte_q   (byte_q)
    );

    hrd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .byte_q (byte_q),
        .result (result)
    );

    hrd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .result    (result),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result_q  (result_q)
    );

    assign data_byte      = result_q.data_byte;
    assign is_payload     = result_q.is_payload;
    assign header_done    = result_q.header_done;
    assign length_known   = result_q.length_known;
    assign content_length = result_q.content_length;
    assign body_count     = result_q.body_count;
    assign last           = result_q.last;

endmodule

// ===== tb/hrd_frame_checker.sv =====
// Watches the byte and result channels of the HTTP response body deframer, predicts
// every result beat from the accepted bytes and compares them field by field.
// Depends on hrd_pkg for the result layout and the character constants.
module hrd_frame_checker
    import hrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  data_byte,
    input  logic        is_payload,
    input  logic        header_done,
    input  logic        length_known,
    input  logic [31:0] content_length,
    input  logic [31:0] body_count,
    input  logic        last,
    output int          fail_count,
    output int          outstanding
);

    localparam logic [63:0] LENGTH_MAX = 64'hFFFF_FFFF;

    phase_t      hdr_phase;
    logic [4:0]  name_pos;
    logic        in_digits;
    logic        digits_halted;
    logic [31:0] parsed_length;
    logic        length_done;
    logic [1:0]  blank_pos;
    logic [31:0] body_total;

    hrd_result_t expected_results[$];
    int          errors;

    function automatic void clear_parser();
        hdr_phase     = PH_HEADER;
        name_pos      = 5'd0;
        in_digits     = 1'b0;
        digits_halted = 1'b0;
        parsed_length = 32'd0;
        length_done   = 1'b0;
        blank_pos     = 2'd0;
        body_total    = 32'd0;
    endfunction

    function automatic hrd_result_t frame_byte(input logic [7:0] b);
        hrd_result_t r;
        logic [4:0]  idx;
        logic [63:0] digit;
        logic        ends_header;
        logic        done;
        r = '0;
        ends_header = 1'b0;
        done = 1'b0;
        r.data_byte = b;
        if (hdr_phase == PH_BODY)
        begin
            r.is_payload = 1'b1;
            ends_header = 1'b1;
            if (body_total != LENGTH_MAX[31:0])
                body_total = body_total + 32'd1;
            done = (body_total >= parsed_length);
        end
        else
        begin
            if (in_digits)
            begin
                if (b == CHAR_CR)
                begin
                    in_digits = 1'b0;
                    length_done = 1'b1;
                end
                else if (!digits_halted && b >= CHAR_ZERO && b <= CHAR_NINE)
                begin
                    digit = 64'(b - CHAR_ZERO);
                    if ({32'd0, parsed_length} > (LENGTH_MAX - digit) / 64'd10)
                        parsed_length = LENGTH_MAX[31:0];
                    else
                        parsed_length = 32'({32'd0, parsed_length} * 64'd10 + digit);
                end
                else
                begin
                    digits_halted = 1'b1;
                end
            end
            else if (!length_done)
            begin
                idx = (name_pos < NAME_LEN) ? name_pos : 5'd0;
                if (b == NAME_TEXT[idx[3:0]])
                    idx = idx + 5'd1;
                else
                    idx = (b == NAME_TEXT[0]) ? 5'd1 : 5'd0;
                if (idx >= NAME_LEN)
                begin
                    in_digits = 1'b1;
                    digits_halted = 1'b0;
                    parsed_length = 32'd0;
                    idx = 5'd0;
                end
                name_pos = idx;
            end

            if (b == (blank_pos[0] ? CHAR_LF : CHAR_CR))
            begin
                if (blank_pos == 2'd3)
                begin
                    ends_header = 1'b1;
                    blank_pos = 2'd0;
                end
                else
                begin
                    blank_pos = blank_pos + 2'd1;
                end
            end
            else
            begin
                blank_pos = (b == CHAR_CR) ? 2'd1 : 2'd0;
            end

            if (ends_header)
            begin
                hdr_phase = PH_BODY;
                body_total = 32'd0;
                if (!length_done || parsed_length == 32'd0)
                    done = 1'b1;
            end
        end

        r.header_done    = ends_header;
        r.length_known   = length_done;
        r.content_length = parsed_length;
        r.body_count     = r.is_payload ? body_total : 32'd0;
        r.last           = done;
        if (done)
            clear_parser();
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        hrd_result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            clear_parser();
            errors = 0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.insert(expected_results.size(), frame_byte(rx_byte));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $error("result beat with no byte waiting for it");
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
                    check_field("is_payload", 32'(want.is_payload), 32'(is_payload));
                    check_field("header_done", 32'(want.header_done), 32'(header_done));
                    check_field("length_known", 32'(want.length_known), 32'(length_known));
                    check_field("content_length", want.content_length, content_length);
                    check_field("body_count", want.body_count, body_count);
                    check_field("last", 32'(want.last), 32'(last));
                end
            end
            fail_count <= errors;
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== tb/http_response_body_deframer_top_test.sv =====
// Drives HTTP responses byte by byte into the deframer, with random input gaps and
// output stalls, and prints the verdict. Depends on hrd_pkg, the deframer RTL and
// hrd_frame_checker, which predicts and compares the result beats.
module http_response_body_deframer_top_test
    import hrd_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  data_byte;
    logic        is_payload;
    logic        header_done;
    logic        length_known;
    logic [31:0] content_length;
    logic [31:0] body_count;
    logic        last;
    int          fail_count;
    int          outstanding;

    logic [7:0]  tx_bytes[$];
    int          bytes_sent;
    int          in_gap_mode;

    http_response_body_deframer_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .data_byte(data_byte),
        .is_payload(is_payload),
        .header_done(header_done),
        .length_known(length_known),
        .content_length(content_length),
        .body_count(body_count),
        .last(last)
    );

    hrd_frame_checker frame_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .data_byte(data_byte),
        .is_payload(is_payload),
        .header_done(header_done),
        .length_known(length_known),
        .content_length(content_length),
        .body_count(body_count),
        .last(last),
        .fail_count(fail_count),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void add_byte(input logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic void add_eol();
        add_byte(CHAR_CR);
        add_byte(CHAR_LF);
    endfunction

    function automatic void add_body(input int n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_header_line();
        int pick;
        add_text("X-Tag: ");
        repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(32, 126)));
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            add_byte(CHAR_CR);
        end
        else if (pick == 1)
        begin
            add_eol();
            add_byte(CHAR_CR);
            add_text("X-Fold: y");
        end
        add_eol();
    endfunction

    task automatic send_queued();
        logic [7:0] b;
        int gap;
        int pick;
        while (tx_bytes.size() > 0)
        begin
            b = tx_bytes.pop_front();
            gap = 0;
            if (in_gap_mode != 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < (in_gap_mode == 1 ? 80 : 50))
                    gap = 0;
                else if (pick < 97)
                    gap = $urandom_range(1, 3);
                else
                    gap = $urandom_range(10, 60);
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            rx_byte <= b;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            bytes_sent++;
        end
    endtask

    initial
    begin : stall_source
        int hold;
        int mode;
        int span;
        hold = 0;
        mode = 0;
        span = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(50, 300);
            end
            span--;
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (mode != 0 && $urandom_range(0, 99) < (mode == 1 ? 15 : 40))
            begin
                hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        int   body_len;
        int   variant;
        int   pick;
        logic paused;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        rx_byte <= 8'd0;
        bytes_sent = 0;
        in_gap_mode = 0;
        paused = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An empty header, a doubled first letter before the name, and a blank
        // line that is broken off and then restarted.
        add_eol();
        add_eol();
        add_text("CContent-Length: 2");
        add_eol();
        add_eol();
        add_byte(8'h00);
        add_byte(8'hFF);
        add_eol();
        add_byte(CHAR_CR);
        add_text("A");
        add_byte(CHAR_CR);
        add_eol();
        add_eol();
        send_queued();

        while (bytes_sent < 1450)
        begin
            in_gap_mode = $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0)
                add_body($urandom_range(1, 12));
            pick = $urandom_range(0, 99);
            if (pick < 75)
                body_len = $urandom_range(1, 16);
            else if (pick < 95)
                body_len = $urandom_range(17, 64);
            else
                body_len = $urandom_range(65, 300);

            add_text("HTTP/1.1 200 OK");
            add_eol();
            repeat ($urandom_range(0, 2)) add_header_line();
            variant = $urandom_range(0, 99);
            if (variant < 60)
            begin
                if (variant < 5)
                    add_text("CContent-Length: ");
                else
                    add_text("Content-Length: ");
                if (variant % 4 == 0)
                    add_text("00");
                add_text($sformatf("%0d", body_len));
                if (variant >= 50)
                    add_text("x7");
                add_eol();
                if (variant >= 45 && variant < 50)
                begin
                    add_text("Content-Length: ");
                    add_text($sformatf("%0d", body_len + 3));
                    add_eol();
                end
            end
            else
            begin
                if (variant < 65)
                    add_text("Content-Length: 0");
                else if (variant < 70)
                    add_text($sformatf("Content-Length:  %0d", body_len));
                else if (variant < 75)
                    add_text($sformatf("content-length: %0d", body_len));
                else if (variant < 80)
                    add_text($sformatf("Content-Length: abc%0d", body_len));
                else if (variant < 85)
                    add_text("Content-Length: ");
                else
                    add_text("Server: test");
                add_eol();
                body_len = 0;
            end
            repeat ($urandom_range(0, 2)) add_header_line();
            add_eol();
            add_body(body_len);
            send_queued();

            if (!paused && bytes_sent >= 700)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                do @(posedge clk); while (outstanding != 0);
            end
        end

        // The length saturates on its last digits, so the block is left in the
        // body of this response when the run ends.
        in_gap_mode = 1;
        add_text("HTTP/1.1 200 OK");
        add_eol();
        add_text("Content-Length: 429496729507");
        add_eol();
        add_eol();
        add_body(24);
        send_queued();

        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== http_response_body_deframer_top.f =====
rtl/hrd_pkg.sv
rtl/hrd_in_stage.sv
rtl/hrd_parser.sv
rtl/hrd_out_stage.sv
rtl/http_response_body_deframer_top.sv
tb/hrd_frame_checker.sv
tb/http_response_body_deframer_top_test.sv
